@@ rtl/slru_pkg.sv @@
// ----------------------------------------------------------------------------
// slru_pkg
// Shared types and codes for the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package slru_pkg;

  // access kinds
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_FETCH  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  // outcome of one access
  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [4:0] data;
  } cfg_t;

endpackage

@@ rtl/slru_stream_if.sv @@
// ----------------------------------------------------------------------------
// slru_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface slru_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ rtl/slru_set_mem.sv @@
// ----------------------------------------------------------------------------
// slru_set_mem
// Set memory, one row per set, registered read. A per-row written
// flag makes an untouched row read back as all zero (no valid line, rank 0).
// ----------------------------------------------------------------------------
module slru_set_mem #(
  parameter  int unsigned SET_W = 6,
  parameter  int unsigned ROW_W = 288,
  localparam int unsigned DEPTH = 2 ** SET_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_q;
  logic [DEPTH-1:0] row_written_q;
  logic             rd_written_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // row written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_written_q <= '0;
      rd_written_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= row_written_q[rd_addr_i];
      end
    end
  end

  // untouched row reads as its reset value
  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule

@@ rtl/slru_update.sv @@
// ----------------------------------------------------------------------------
// slru_update
// Lookup and LRU update of one set row: tag match, empty-way fill or
// eviction of the oldest way, and rank ageing.
// ----------------------------------------------------------------------------
module slru_update
  import slru_pkg::*;
#(
  parameter  int unsigned MAX_WAYS = 8,
  localparam int unsigned RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int unsigned NW_W     = $clog2(MAX_WAYS + 1)
) (
  input  logic [NW_W-1:0]                    nways_i,
  input  logic [ADDR_W-1:0]                  tag_i,
  input  logic [MAX_WAYS-1:0]                valid_i,
  input  logic [MAX_WAYS-1:0][ADDR_W-1:0]    tags_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_i,
  output logic [MAX_WAYS-1:0]                valid_o,
  output logic [MAX_WAYS-1:0][ADDR_W-1:0]    tags_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_o,
  output outcome_e                           outcome_o
);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] empty_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [WAY_W-1:0]    victim_way;
  logic [RANK_W-1:0]   victim_rank;
  logic [WAY_W-1:0]    sel_way;
  logic [RANK_W-1:0]   age_limit;
  logic                no_limit;

  // per-way match and empty flags
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]    = NW_W'(i) < nways_i;
      hit_vec[i]   = in_use[i] && valid_i[i] && (tags_i[i] == tag_i);
      empty_vec[i] = in_use[i] && !valid_i[i];
    end
  end

  // lowest matching and lowest empty way
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (empty_vec[i]) begin
        empty_way = WAY_W'(i);
      end
    end
  end

  // oldest in-use way, lowest index on a tie
  always_comb begin
    victim_way  = '0;
    victim_rank = ranks_i[0];
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (ranks_i[i] > victim_rank)) begin
        victim_rank = ranks_i[i];
        victim_way  = WAY_W'(i);
      end
    end
  end

  // choose the way to touch
  always_comb begin
    if (|hit_vec) begin
      sel_way   = hit_way;
      age_limit = ranks_i[hit_way];
      no_limit  = 1'b0;
      outcome_o = OUT_HIT;
    end else if (|empty_vec) begin
      sel_way   = empty_way;
      age_limit = '0;
      no_limit  = 1'b1;
      outcome_o = OUT_FILL;
    end else begin
      sel_way   = victim_way;
      age_limit = victim_rank;
      no_limit  = 1'b0;
      outcome_o = OUT_EVICT;
    end
  end

  // age younger lines, selected way becomes most recent
  always_comb begin
    valid_o = valid_i;
    tags_o  = tags_i;
    ranks_o = ranks_i;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && (WAY_W'(i) != sel_way) && valid_i[i] &&
          (no_limit || (ranks_i[i] < age_limit)) && (ranks_i[i] < RANK_MAX)) begin
        ranks_o[i] = ranks_i[i] + RANK_W'(1);
      end
    end
    valid_o[sel_way] = 1'b1;
    tags_o[sel_way]  = tag_i;
    ranks_o[sel_way] = '0;
  end

endmodule

@@ rtl/set_assoc_lru_cache_sim.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache simulator with true LRU replacement and saturating
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// One item is handled at a time. For a load or store the set row is read
// from the set memory in the accept cycle, then looked up, updated and
// written back in a read-modify-write state, whose result goes to the
// output register. A modify adds a second access in a further state,
// working on the updated row held in a register rather than a fresh read.
// An instruction fetch is answered in its accept cycle and leaves the cache
// alone. The next item is taken once the sequencer is idle again, even while
// the result waits to be collected, but not while the skid register, which
// holds a second result, is full. The set memory needs no clearing pass
// after reset: a written flag per set makes an untouched set read as empty.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim
  import slru_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  slru_stream_if.sink   cfg_i,
  slru_stream_if.sink   in_i,
  slru_stream_if.source out_o
);

  localparam int unsigned SET_W  = MAX_SET_BITS;
  localparam int unsigned SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam int unsigned SH_W   = $clog2(ADDR_W + MAX_SET_BITS);
  localparam int unsigned RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W   = $clog2(MAX_WAYS + 1);
  localparam int unsigned RANKS_W = MAX_WAYS * RANK_W;
  localparam int unsigned TAGS_W  = MAX_WAYS * ADDR_W;
  localparam int unsigned ROW_W   = MAX_WAYS + TAGS_W + RANKS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC1,
    S_ACC2
  } state_e;

  state_e state_q;

  // configuration registers
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] block_bits_q;

  // item in flight
  logic [1:0]        op_q;
  logic [SET_W-1:0]  set_q;
  logic [ADDR_W-1:0] tag_q;
  logic [ROW_W-1:0]  row_q;
  outcome_e          first_q;

  logic [CNT_W-1:0] hit_q, hit_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic [CNT_W-1:0] evict_q, evict_d;

  logic out_vld_q, skid_vld_q;
  out_t out_q, skid_q;

  logic              in_acc;
  logic              out_drain;
  logic [SB_W-1:0]   sb_eff;
  logic [SH_W-1:0]   tag_shift;
  logic [SET_W-1:0]  in_set;
  logic [ADDR_W-1:0] in_tag;
  logic [NW_W-1:0]   nways;

  logic              mem_rd_en;
  logic [ROW_W-1:0]  mem_rd_row;
  logic              mem_wr_en;
  logic              in_access;
  logic [ROW_W-1:0]  acc_row;
  logic [ROW_W-1:0]  new_row;
  outcome_e          acc_outcome;

  logic [MAX_WAYS-1:0]             upd_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0] upd_tags;
  logic [MAX_WAYS-1:0][RANK_W-1:0] upd_ranks;

  logic finish;
  out_t res;

  // handshakes
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE) && !skid_vld_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_drain   = out_vld_q && out_o.ready;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // effective set bits and way count
  always_comb begin
    if (32'(set_bits_q) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(set_bits_q);
    end
    if (ways_q == 4'd0) begin
      nways = NW_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      nways = NW_W'(MAX_WAYS);
    end else begin
      nways = NW_W'(ways_q);
    end
  end

  // address split into set and tag
  assign tag_shift = SH_W'(block_bits_q) + SH_W'(sb_eff);
  assign in_set    = SET_W'(in_i.payload.address >> block_bits_q) &
                     ~({SET_W{1'b1}} << sb_eff);
  assign in_tag    = (tag_shift >= SH_W'(ADDR_W)) ? '0 :
                     (in_i.payload.address >> tag_shift);

  // set memory
  assign mem_rd_en = in_acc && (in_i.payload.op != OP_FETCH);
  assign in_access = (state_q == S_ACC1) || (state_q == S_ACC2);
  assign mem_wr_en = in_access;

  slru_set_mem #(
    .SET_W (SET_W),
    .ROW_W (ROW_W)
  ) u_set_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (in_set),
    .rd_data_o (mem_rd_row),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (set_q),
    .wr_data_i (new_row)
  );

  // second access of a modify works on the forwarded row
  assign acc_row = (state_q == S_ACC2) ? row_q : mem_rd_row;

  slru_update #(
    .MAX_WAYS (MAX_WAYS)
  ) u_update (
    .nways_i   (nways),
    .tag_i     (tag_q),
    .valid_i   (acc_row[ROW_W-1 -: MAX_WAYS]),
    .tags_i    (acc_row[RANKS_W +: TAGS_W]),
    .ranks_i   (acc_row[0 +: RANKS_W]),
    .valid_o   (upd_valid),
    .tags_o    (upd_tags),
    .ranks_o   (upd_ranks),
    .outcome_o (acc_outcome)
  );

  assign new_row = {upd_valid, upd_tags, upd_ranks};

  // saturating totals
  always_comb begin
    hit_d   = hit_q;
    miss_d  = miss_q;
    evict_d = evict_q;
    if (in_access) begin
      if (acc_outcome == OUT_HIT) begin
        if (hit_q != '1) hit_d = hit_q + CNT_W'(1);
      end else begin
        if (miss_q != '1) miss_d = miss_q + CNT_W'(1);
      end
      if (acc_outcome == OUT_EVICT) begin
        if (evict_q != '1) evict_d = evict_q + CNT_W'(1);
      end
    end
  end

  // result of a finished item
  always_comb begin
    finish = 1'b0;
    res.outcome        = acc_outcome;
    res.second_hit     = 1'b0;
    res.hit_total      = hit_d;
    res.miss_total     = miss_d;
    res.eviction_total = evict_d;
    case (state_q)
      S_IDLE: begin
        res.outcome = OUT_IGNORED;
        finish      = in_acc && (in_i.payload.op == OP_FETCH);
      end
      S_ACC1: begin
        finish = (op_q != OP_MODIFY);
      end
      S_ACC2: begin
        res.outcome    = first_q;
        res.second_hit = (acc_outcome == OUT_HIT);
        finish         = 1'b1;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd4;
      ways_q       <= 4'd1;
      block_bits_q <= 5'd4;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.payload.index)
        REG_SET_BITS:   set_bits_q   <= cfg_i.payload.data[2:0];
        REG_WAYS:       ways_q       <= cfg_i.payload.data[3:0];
        REG_BLOCK_BITS: block_bits_q <= cfg_i.payload.data;
        default:        ;
      endcase
    end
  end

  // sequencer, totals and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hit_q      <= '0;
      miss_q     <= '0;
      evict_q    <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      evict_q <= evict_d;
      case (state_q)
        S_IDLE: begin
          if (mem_rd_en) state_q <= S_ACC1;
        end
        S_ACC1: begin
          state_q <= (op_q == OP_MODIFY) ? S_ACC2 : S_IDLE;
        end
        S_ACC2: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (finish) begin
        if (!out_vld_q || out_drain) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_drain) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.payload.op;
      set_q <= in_set;
      tag_q <= in_tag;
    end
    if (state_q == S_ACC1) begin
      row_q   <= new_row;
      first_q <= acc_outcome;
    end
    if (finish) begin
      if (!out_vld_q || out_drain) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_drain && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

`ifndef SYNTH
  // a waiting second result always sits behind a valid output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result with the output register empty");

  // evictions are a subset of misses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evict_q <= miss_q)
    else $error("eviction total exceeds miss total");

  // hit total only steps by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q != $past(hit_q)) |-> (hit_q == $past(hit_q) + CNT_W'(1)))
    else $error("hit total changed by more than one");

  // second access only follows a modify's first access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC2) |-> ($past(state_q) == S_ACC1) && (op_q == OP_MODIFY))
    else $error("second access without a modify");

  // no new item while an access is still updating the set memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_rd_en |-> !mem_wr_en && (state_q == S_IDLE))
    else $error("set memory read overlaps a write-back");
`endif

endmodule
